@@ sv/pitch_speed_hold_limiter_assert.svh @@
// Assertion macros for the pitch speed/hold limiter.
// No dependencies; included by files that carry concurrent checks.
`ifndef PITCH_SPEED_HOLD_LIMITER_ASSERT_SVH
`define PITCH_SPEED_HOLD_LIMITER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Check a property on the rising clock, ignored while reset is low.
`define PSH_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on the rising clock, also during reset.
`define PSH_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define PSH_ASSERT(name, clk, rst_n, prop, msg)
`define PSH_ASSERT_ALWAYS(name, clk, prop, msg)

`endif

`endif

@@ sv/psh_pkg.sv @@
// Shared types, constants and helpers for the pitch speed/hold limiter.
// No dependencies; imported by every module of the block.
`default_nettype none

package psh_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_ENTER_THR  = 3'd0;
    localparam logic [2:0] REG_EXIT_THR   = 3'd1;
    localparam logic [2:0] REG_FULL_SCALE = 3'd2;
    localparam logic [2:0] REG_MAX_SPEED  = 3'd3;
    localparam logic [2:0] REG_LOWER_OFF  = 3'd4;
    localparam logic [2:0] REG_UPPER_OFF  = 3'd5;
    localparam logic [2:0] REG_SLOW_ZONE  = 3'd6;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 21;

    // Shared divider geometry
    localparam int DIV_W      = 36;  // dividend / quotient width
    localparam int DVR_W      = 20;  // divisor width
    localparam int DIV_CNT_W  = 6;
    localparam int DIV1_SHIFT = 10;  // 26-bit dividend left-aligned in DIV_W
    localparam logic [DIV_CNT_W-1:0] DIV1_STEPS = 6'd26;
    localparam logic [DIV_CNT_W-1:0] DIV2_STEPS = 6'd36;

    typedef struct packed {
        logic [10:0]        enter_threshold;
        logic [10:0]        exit_threshold;
        logic [10:0]        stick_full_scale;
        logic [14:0]        max_speed;
        logic signed [20:0] lower_offset;
        logic signed [20:0] upper_offset;
        logic [19:0]        slow_zone;
    } t_cfg;

    typedef struct packed {
        logic signed [11:0] stick;
        logic signed [31:0] position;
        logic signed [31:0] home_position;
        logic               reinit;
    } t_in;

    typedef struct packed {
        logic               speed_active;
        logic signed [15:0] speed_command;
        logic signed [31:0] hold_target;
        logic               reset_loop;
        logic               at_limit;
    } t_out;

    // Controller to datapath
    typedef struct packed {
        logic load;       // capture request, apply reinit
        logic prep;       // soft limits
        logic eval;       // remaining distance, move decision, stick product
        logic hold_upd;   // latch and clamp hold, build hold result
        logic div_start;
        logic div_sel;    // 0: full-scale divide, 1: taper divide
        logic sat;        // saturate first quotient, decide taper
        logic mul;        // speed magnitude times remaining distance
        logic speed_fin;  // build speed result
        logic out_load;   // move result into output register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic moving;
        logic taper;
        logic div_busy;
        logic div_done;
    } t_sts;

    // Saturate a 33-bit signed sum to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v[32] != v[31]) begin
            r = v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ sv/psh_div.sv @@
// Restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on psh_pkg for its widths.
`default_nettype none

module psh_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [psh_pkg::DIV_W-1:0]     i_dividend,
    input  wire logic [psh_pkg::DVR_W-1:0]     i_divisor,
    input  wire logic [psh_pkg::DIV_CNT_W-1:0] i_steps,
    output logic                               o_busy,
    output logic                               o_done,
    output logic [psh_pkg::DIV_W-1:0]          o_quotient
);
    import psh_pkg::*;

    logic [DIV_W-1:0]     r_dq;
    logic [DVR_W-1:0]     r_rem;
    logic [DVR_W-1:0]     r_dvr;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [DVR_W:0] shifted;
    logic [DVR_W:0] trial;
    logic           fits;

    assign shifted = {r_rem, r_dq[DIV_W-1]};
    assign trial   = shifted - {1'b0, r_dvr};
    assign fits    = !trial[DVR_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dq  <= i_dividend;
            r_dvr <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dq  <= {r_dq[DIV_W-2:0], fits};
            r_rem <= fits ? trial[DVR_W-1:0] : shifted[DVR_W-1:0];
        end
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_dq;

endmodule

`default_nettype wire

@@ sv/psh_cfg.sv @@
// Configuration register file of the pitch speed/hold limiter.
// Depends on psh_pkg for the register layout and indexes.
`default_nettype none

module psh_cfg (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [psh_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [psh_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output psh_pkg::t_cfg                       o_cfg
);
    import psh_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enter_threshold  <= 11'd20;
            r_cfg.exit_threshold   <= 11'd10;
            r_cfg.stick_full_scale <= 11'd660;
            r_cfg.max_speed        <= 15'd1000;
            r_cfg.lower_offset     <= -21'sd4096;
            r_cfg.upper_offset     <= 21'sd4096;
            r_cfg.slow_zone        <= 20'd512;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_ENTER_THR:  r_cfg.enter_threshold  <= i_cfg_data[10:0];
                REG_EXIT_THR:   r_cfg.exit_threshold   <= i_cfg_data[10:0];
                REG_FULL_SCALE: r_cfg.stick_full_scale <= i_cfg_data[10:0];
                REG_MAX_SPEED:  r_cfg.max_speed        <= i_cfg_data[14:0];
                REG_LOWER_OFF:  r_cfg.lower_offset     <= i_cfg_data[20:0];
                REG_UPPER_OFF:  r_cfg.upper_offset     <= i_cfg_data[20:0];
                REG_SLOW_ZONE:  r_cfg.slow_zone        <= i_cfg_data[19:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

@@ sv/psh_dp.sv @@
// Datapath: mode/hold state, limit arithmetic, shared divider, result registers.
// Depends on psh_pkg and psh_div; driven by psh_ctrl through t_cmd.
`default_nettype none

module psh_dp (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire psh_pkg::t_cfg i_cfg,
    input  wire psh_pkg::t_in  i_in_data,
    input  wire psh_pkg::t_cmd i_cmd,
    output psh_pkg::t_sts      o_sts,
    output psh_pkg::t_out      o_out_data
);
    import psh_pkg::*;

    // Persistent state
    logic               r_mode;
    logic signed [31:0] r_hold;

    // Request and intermediate values
    logic signed [11:0] r_stick;
    logic signed [31:0] r_pos;
    logic signed [31:0] r_home;
    logic signed [31:0] r_lower;
    logic signed [31:0] r_upper;
    logic signed [32:0] r_rem;
    logic               r_moving;
    logic               r_at_b;
    logic [25:0]        r_prod;
    logic [15:0]        r_smag;
    logic signed [15:0] r_speed;
    logic               r_taper;
    logic [DIV_W-1:0]   r_prod2;
    t_out               r_res;
    t_out               r_out;

    // Soft limits
    logic signed [32:0] lo_sum;
    logic signed [32:0] up_sum;

    assign lo_sum = $signed({r_home[31], r_home})
                  + $signed({{12{i_cfg.lower_offset[20]}}, i_cfg.lower_offset});
    assign up_sum = $signed({r_home[31], r_home})
                  + $signed({{12{i_cfg.upper_offset[20]}}, i_cfg.upper_offset});

    // Move decision
    logic               neg;
    logic               zero;
    logic [11:0]        stick_u;
    logic [11:0]        mag;
    logic [10:0]        thr;
    logic signed [32:0] rem_lo;
    logic signed [32:0] rem_up;
    logic signed [32:0] remaining;
    logic               at_b;
    logic [26:0]        prod_full;

    assign neg       = r_stick[11];
    assign zero      = (r_stick == 12'sd0);
    assign stick_u   = r_stick;
    assign mag       = neg ? (~stick_u + 12'd1) : stick_u;
    assign thr       = r_mode ? i_cfg.exit_threshold : i_cfg.enter_threshold;
    assign rem_lo    = $signed({r_pos[31], r_pos}) - $signed({r_lower[31], r_lower});
    assign rem_up    = $signed({r_upper[31], r_upper}) - $signed({r_pos[31], r_pos});
    assign remaining = neg ? rem_lo : rem_up;
    assign at_b      = !zero && (remaining[32] || (remaining == 33'sd0));
    assign prod_full = {15'd0, mag} * {12'd0, i_cfg.max_speed};

    // Hold latch and clamp, lower first so the upper limit wins
    logic signed [31:0] boundary;
    logic signed [31:0] base;
    logic signed [31:0] h_lo;
    logic signed [31:0] h_fin;

    assign boundary = neg ? r_lower : r_upper;
    assign base     = r_at_b ? boundary : (r_mode ? r_pos : r_hold);
    assign h_lo     = (base < r_lower) ? r_lower : base;
    assign h_fin    = (h_lo > r_upper) ? r_upper : h_lo;

    // Shared divider
    logic [10:0]          full_scale;
    logic [DIV_W-1:0]     div_dividend;
    logic [DVR_W-1:0]     div_divisor;
    logic [DIV_CNT_W-1:0] div_steps;
    logic                 div_busy;
    logic                 div_done;
    logic [DIV_W-1:0]     div_q;

    assign full_scale   = (i_cfg.stick_full_scale == 11'd0) ? 11'd1 : i_cfg.stick_full_scale;
    assign div_dividend = i_cmd.div_sel ? r_prod2 : {r_prod, {DIV1_SHIFT{1'b0}}};
    assign div_divisor  = i_cmd.div_sel ? i_cfg.slow_zone : {9'd0, full_scale};
    assign div_steps    = i_cmd.div_sel ? DIV2_STEPS : DIV1_STEPS;

    psh_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .i_steps    (div_steps),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // Saturate the full-scale quotient; negative side reaches one count further
    logic [25:0] q1;
    logic [25:0] q1_lim;
    logic [15:0] smag;
    logic [15:0] q2;
    logic [15:0] tap_speed;
    logic        taper;

    assign q1        = div_q[25:0];
    assign q1_lim    = neg ? 26'd32768 : 26'd32767;
    assign smag      = (q1 > q1_lim) ? q1_lim[15:0] : q1[15:0];
    assign taper     = (i_cfg.slow_zone != 20'd0)
                     && (r_rem < $signed({13'd0, i_cfg.slow_zone}));
    assign q2        = div_q[15:0];
    assign tap_speed = neg ? (~q2 + 16'd1) : q2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_hold <= '0;
        end else if (i_cmd.load && i_in_data.reinit) begin
            r_mode <= 1'b0;
            r_hold <= i_in_data.home_position;
        end else if (i_cmd.hold_upd) begin
            r_mode <= 1'b0;
            r_hold <= h_fin;
        end else if (i_cmd.speed_fin) begin
            r_mode <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_stick <= i_in_data.stick;
            r_pos   <= i_in_data.position;
            r_home  <= i_in_data.home_position;
        end
        if (i_cmd.prep) begin
            r_lower <= sat32(lo_sum);
            r_upper <= sat32(up_sum);
        end
        if (i_cmd.eval) begin
            r_rem    <= remaining;
            r_at_b   <= at_b;
            r_moving <= ({1'b0, mag} > {2'b0, thr}) && !at_b;
            r_prod   <= prod_full[25:0];
        end
        if (i_cmd.sat) begin
            r_smag  <= smag;
            r_speed <= neg ? (~smag + 16'd1) : smag;
            r_taper <= taper;
        end
        if (i_cmd.mul) begin
            r_prod2 <= {20'd0, r_smag} * {16'd0, r_rem[19:0]};
        end
        if (i_cmd.hold_upd) begin
            r_res.speed_active  <= 1'b0;
            r_res.speed_command <= '0;
            r_res.hold_target   <= h_fin;
            r_res.reset_loop    <= r_mode;
            r_res.at_limit      <= r_at_b;
        end
        if (i_cmd.speed_fin) begin
            r_res.speed_active  <= 1'b1;
            r_res.speed_command <= r_taper ? tap_speed : r_speed;
            r_res.hold_target   <= '0;
            r_res.reset_loop    <= !r_mode;
            r_res.at_limit      <= 1'b0;
        end
        if (i_cmd.out_load) begin
            r_out <= r_res;
        end
    end

    assign o_sts.moving   = r_moving;
    assign o_sts.taper    = r_taper;
    assign o_sts.div_busy = div_busy;
    assign o_sts.div_done = div_done;
    assign o_out_data     = r_out;

endmodule

`default_nettype wire

@@ sv/psh_ctrl.sv @@
// Sequencer of the pitch speed/hold limiter and owner of both handshakes.
// Depends on psh_pkg for the command and status structs.
`default_nettype none

module psh_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    input  wire psh_pkg::t_sts i_sts,
    output psh_pkg::t_cmd      o_cmd
);
    import psh_pkg::*;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_PREP   = 4'd1;
    localparam logic [3:0] ST_EVAL   = 4'd2;
    localparam logic [3:0] ST_DECIDE = 4'd3;
    localparam logic [3:0] ST_DIV1   = 4'd4;
    localparam logic [3:0] ST_SAT    = 4'd5;
    localparam logic [3:0] ST_MUL    = 4'd6;
    localparam logic [3:0] ST_TAPER  = 4'd7;
    localparam logic [3:0] ST_DIV2   = 4'd8;
    localparam logic [3:0] ST_FIN    = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_PREP;
                end
            end
            ST_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = ST_EVAL;
            end
            ST_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (i_sts.moving) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = ST_DIV1;
                end else begin
                    o_cmd.hold_upd = 1'b1;
                    n_state        = ST_FIN;
                end
            end
            ST_DIV1: begin
                if (i_sts.div_done) begin
                    n_state = ST_SAT;
                end
            end
            ST_SAT: begin
                o_cmd.sat = 1'b1;
                n_state   = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_TAPER;
            end
            ST_TAPER: begin
                // taper only inside the slow zone, else finish with the saturated speed
                if (i_sts.taper) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = 1'b1;
                    n_state         = ST_DIV2;
                end else begin
                    o_cmd.speed_fin = 1'b1;
                    n_state         = ST_FIN;
                end
            end
            ST_DIV2: begin
                o_cmd.div_sel = 1'b1;
                if (i_sts.div_done) begin
                    o_cmd.speed_fin = 1'b1;
                    n_state         = ST_FIN;
                end
            end
            ST_FIN: begin
                // hold the result until the output register frees up
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

@@ sv/pitch_speed_hold_limiter.sv @@
// Pitch speed/hold limiter: one request in, one result out, handled one at a
// time. A hold result skips the divider, an untapered speed command uses the
// full-scale divide, and a speed command inside the slow zone adds the taper
// divide. The shared restoring divider produces one quotient bit per cycle
// (26 steps for the full-scale divide, 36 for the taper). A finished result
// waits in the output register while the next request is taken in.
// Configuration registers may be written whenever no request is in flight.
`default_nettype none

`include "pitch_speed_hold_limiter_assert.svh"

module pitch_speed_hold_limiter (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire psh_pkg::t_in                   i_in_data,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output psh_pkg::t_out                       o_out_data,
    input  wire logic                           i_cfg_we,
    input  wire logic [psh_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [psh_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import psh_pkg::*;

    t_cfg cfg;
    t_cmd cmd;
    t_sts sts;

    psh_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    psh_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    psh_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_in_data  (i_in_data),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_out_data (o_out_data)
    );

    `PSH_ASSERT(a_idle_div_quiet, i_clk, i_rst_n, !o_in_stall |-> !sts.div_busy, "divider busy while idle")
    `PSH_ASSERT(a_one_step, i_clk, i_rst_n, $onehot0({cmd.load, cmd.prep, cmd.eval, cmd.hold_upd, cmd.div_start, cmd.sat, cmd.mul, cmd.speed_fin, cmd.out_load}), "overlapping datapath commands")
    `PSH_ASSERT(a_div_runs, i_clk, i_rst_n, cmd.div_start |=> sts.div_busy, "divider did not start")
    `PSH_ASSERT(a_hold_zero_speed, i_clk, i_rst_n, (o_out_valid && !o_out_data.speed_active) |-> (o_out_data.speed_command == 16'sd0), "hold result with speed")
    `PSH_ASSERT(a_speed_no_limit, i_clk, i_rst_n, (o_out_valid && o_out_data.speed_active) |-> (!o_out_data.at_limit && o_out_data.hold_target == 32'sd0), "speed result at limit")

endmodule

`default_nettype wire
